// ----- design/lkv_pkg.sv -----
// Package for the LRU key-value store: command codes, field widths,
// sequencer state type and the controller-to-datapath command bundle.
// No dependencies.
package lkv_pkg;

    localparam int CMD_W = 3;
    localparam int CAP_W = 5;
    localparam int OCC_W = 5;

    localparam logic [CMD_W-1:0] CMD_GET      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUT      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_UPDATE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;     // capture the input beat
        logic match;    // run the associative compare
        logic update;   // apply the command to the entries
    } t_dp_ctrl;

endpackage

// ----- design/lkv_ctrl.sv -----
// Sequencer for the LRU key-value store: steps each beat through
// capture, match, update and result hold. Depends on lkv_pkg.
module lkv_ctrl
    import lkv_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dp_ctrl o_dp
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH:  n_state = S_UPDATE;
            S_UPDATE: n_state = S_DONE;
            S_DONE: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_dp        = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_dp.load  = i_in_valid;
            end
            S_MATCH:  o_dp.match  = 1'b1;
            S_UPDATE: o_dp.update = 1'b1;
            S_DONE:   o_out_valid = 1'b1;
            default: begin
            end
        endcase
    end

endmodule

// ----- design/lkv_datapath.sv -----
// Datapath of the LRU key-value store: key CAM cells, recency ranks,
// valid bits, entry count, capacity register and the value memory.
// Depends on lkv_pkg.
module lkv_datapath
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_ctrl              i_dp,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_cfg_we,
    input  logic [CAP_W-1:0]      i_cfg_data,
    output logic                  o_found,
    output logic [VALUE_BITS-1:0] o_read_value,
    output logic [OCC_W-1:0]      o_occupancy
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // request
    logic [CMD_W-1:0]      r_cmd;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [CAP_W-1:0]      r_cap;

    // entry state
    logic [KEY_BITS-1:0]   r_keys  [ENTRIES];
    logic [VALUE_BITS-1:0] r_mem   [ENTRIES];
    logic [ENTRIES-1:0]    r_valid;
    logic [ENTRIES-1:0]    n_valid;
    logic [IDX_W-1:0]      r_rank  [ENTRIES];
    logic [IDX_W-1:0]      n_rank  [ENTRIES];
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;

    // match results
    logic                  r_hit;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [IDX_W-1:0]      r_hit_rank;
    logic [IDX_W-1:0]      r_free_idx;
    logic [IDX_W-1:0]      r_vic_idx;
    logic                  r_full;

    // result
    logic                  r_found;
    logic                  r_get_hit;
    logic [VALUE_BITS-1:0] r_rd_data;

    logic                  hit;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      hit_rank;
    logic [IDX_W-1:0]      free_idx;
    logic [IDX_W-1:0]      vic_idx;
    logic [CNT_W-1:0]      count_m1;
    logic [IDX_W-1:0]      last_rank;
    logic [CMP_W-1:0]      eff_cap;
    logic [CMP_W-1:0]      count_ext;

    logic                  touch_en;
    logic [IDX_W-1:0]      touch_idx;
    logic [IDX_W-1:0]      touch_rank;
    logic                  ins_en;
    logic                  erase_en;
    logic                  clear_en;
    logic                  key_we;
    logic [IDX_W-1:0]      key_idx;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_idx;
    logic                  found;

    assign count_m1  = r_count - CNT_W'(1);
    assign last_rank = count_m1[IDX_W-1:0];
    assign count_ext = CMP_W'(r_count);

    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(r_cap) > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = CMP_W'(r_cap);
        end
    end

    // associative compare; keys are unique among valid entries
    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        hit_rank = '0;
        vic_idx  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_valid[i] && r_keys[i] == r_key) begin
                hit      = 1'b1;
                hit_idx  = hit_idx | IDX_W'(i);
                hit_rank = hit_rank | r_rank[i];
            end
            if (r_valid[i] && r_rank[i] == last_rank) begin
                vic_idx = vic_idx | IDX_W'(i);
            end
        end
    end

    always_comb begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp.load) begin
            r_cmd   <= i_cmd;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (i_dp.match) begin
            r_hit      <= hit;
            r_hit_idx  <= hit_idx;
            r_hit_rank <= hit_rank;
            r_free_idx <= free_idx;
            r_vic_idx  <= vic_idx;
            r_full     <= count_ext >= eff_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    // command decode for the update step
    always_comb begin
        touch_en = 1'b0;
        ins_en   = 1'b0;
        erase_en = 1'b0;
        clear_en = 1'b0;
        mem_we   = 1'b0;
        found    = 1'b0;
        case (r_cmd)
            CMD_GET: begin
                touch_en = r_hit;
                found    = r_hit;
            end
            CMD_PUT: begin
                touch_en = r_hit | r_full;
                ins_en   = !r_hit && !r_full;
                mem_we   = 1'b1;
                found    = r_hit;
            end
            CMD_ERASE: begin
                erase_en = r_hit;
                found    = r_hit;
            end
            CMD_CONTAINS: found = r_hit;
            CMD_CLEAR:    clear_en = 1'b1;
            default: begin
            end
        endcase
        touch_en   = touch_en & i_dp.update;
        ins_en     = ins_en & i_dp.update;
        erase_en   = erase_en & i_dp.update;
        clear_en   = clear_en & i_dp.update;
        mem_we     = mem_we & i_dp.update;
        touch_idx  = r_hit ? r_hit_idx : r_vic_idx;
        touch_rank = r_hit ? r_hit_rank : last_rank;
        key_we     = (touch_en && !r_hit) || ins_en;
        key_idx    = ins_en ? r_free_idx : r_vic_idx;
        mem_idx    = r_hit ? r_hit_idx : (r_full ? r_vic_idx : r_free_idx);
    end

    always_comb begin
        n_count = r_count;
        for (int i = 0; i < ENTRIES; i++) begin
            n_valid[i] = r_valid[i];
            n_rank[i]  = r_rank[i];
            if (touch_en) begin
                if (IDX_W'(i) == touch_idx) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && r_rank[i] < touch_rank) begin
                    n_rank[i] = r_rank[i] + IDX_W'(1);
                end
            end
            if (ins_en) begin
                if (IDX_W'(i) == r_free_idx) begin
                    n_valid[i] = 1'b1;
                    n_rank[i]  = '0;
                end else if (r_valid[i]) begin
                    n_rank[i] = r_rank[i] + IDX_W'(1);
                end
            end
            if (erase_en) begin
                if (IDX_W'(i) == r_hit_idx) begin
                    n_valid[i] = 1'b0;
                    n_rank[i]  = '0;
                end else if (r_valid[i] && r_rank[i] > r_hit_rank) begin
                    n_rank[i] = r_rank[i] - IDX_W'(1);
                end
            end
            if (clear_en) begin
                n_valid[i] = 1'b0;
                n_rank[i]  = '0;
            end
        end
        if (ins_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (erase_en) begin
            n_count = count_m1;
        end else if (clear_en) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (key_we && key_idx == IDX_W'(i)) begin
                r_keys[i] <= r_key;
            end
        end
    end

    // value memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_idx] <= r_value;
        end
        if (i_dp.update) begin
            r_rd_data <= r_mem[r_hit_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp.update) begin
            r_found   <= found;
            r_get_hit <= (r_cmd == CMD_GET) && r_hit;
        end
    end

    assign o_found      = r_found;
    assign o_read_value = r_get_hit ? r_rd_data : '0;
    assign o_occupancy  = count_ext[OCC_W-1:0];

endmodule

// ----- design/lru_key_value_store.sv -----
// Top level of the LRU key-value store: stream ports, beat packing,
// sequencer and datapath. Depends on lkv_pkg, lkv_ctrl, lkv_datapath.
//
// Fully associative key-value store with least-recently-used replacement.
// Each input beat carries a command in s_axis_tuser (0 get, 1 put, 2 erase,
// 3 contains, 4 clear) with key and value in s_axis_tdata, and yields one
// output beat with key_found, read_value and occupancy. Beats are handled
// one at a time: an item steps through capture, parallel key match, update
// of ranks and value memory, and result, and the result is held until
// m_axis_tready; the next beat is taken in the cycle after the result is
// delivered. The value memory read port sets the update-to-result step. The
// capacity register resets to 16; 0 acts as 1 and values above ENTRIES act
// as ENTRIES. It may be written only while no beat is in flight.
module lru_key_value_store
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // lookup_key, write_value, zero pad
    input  logic [((KEY_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // cmd
    input  logic [CMD_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // key_found, read_value, occupancy, zero pad
    output logic [((VALUE_BITS + OCC_W + 8) / 8) * 8 - 1:0] m_axis_tdata,
    input  logic                  i_cfg_wr_en,
    input  logic [CAP_W-1:0]      i_cfg_wr_data
);

    t_dp_ctrl              dp_ctrl;
    logic                  found;
    logic [VALUE_BITS-1:0] read_value;
    logic [OCC_W-1:0]      occupancy;

    lkv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_dp        (dp_ctrl)
    );

    lkv_datapath #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dp         (dp_ctrl),
        .i_cmd        (s_axis_tuser),
        .i_key        (s_axis_tdata[KEY_BITS-1:0]),
        .i_value      (s_axis_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS]),
        .i_cfg_we     (i_cfg_wr_en),
        .i_cfg_data   (i_cfg_wr_data),
        .o_found      (found),
        .o_read_value (read_value),
        .o_occupancy  (occupancy)
    );

    always_comb begin
        m_axis_tdata                                    = '0;
        m_axis_tdata[0]                                 = found;
        m_axis_tdata[VALUE_BITS:1]                      = read_value;
        m_axis_tdata[VALUE_BITS+OCC_W:VALUE_BITS+1]     = occupancy;
    end

endmodule
